[rtl/fpba_pkg.sv]
// Shared codes and control types for the fit policy block allocator.
`default_nettype none

package fpba_pkg;

  // command codes (s_axis tuser)
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // placement policies; the unused code acts as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [1:0] FIT_MODE_RST    = FIT_FIRST;
  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  // totals saturate here
  localparam logic [19:0] FRAG_MAX = 20'hFFFFF;

  // sequencer to scan unit
  typedef struct packed {
    logic clear;       // start of a new command
    logic step;        // one entry presented
    logic fix;         // apply the allocation to the totals
    logic alloc;       // command is an allocate
    logic entry_used;  // used mark of the presented entry
  } scan_ctrl_t;

endpackage

`default_nettype wire

[rtl/fit_policy_block_allocator.sv]
// Top level of the fit policy block allocator: sequencer, used marks and ports.
`default_nettype none

// Block table allocator with first, best and worst fit placement. A load
// command (tuser 0) writes one block's size and clears its used mark; an
// allocate command (tuser 1) scans blocks 0 to n-1, n = min(block_count,
// NUM_BLOCKS), through one memory read port and one comparator, shrinks the
// chosen block and marks it used. Every command returns one result with the
// found flag and the chosen index and both fragmentation totals, taken after
// the update and saturated to 20 bits. The scan gathers the totals as it goes,
// so no second pass is needed. One item is in work at a time: an allocate
// that places its request steps through accept, the block reads, one read
// drain, the table update, the totals fix and the result load; one that finds
// nothing skips the totals fix. A load steps through accept, the table write,
// the block reads, the read drain, the update slot and the result load. With
// n = 0 nothing is read: an allocate goes from accept straight to the result
// load and a load adds only the table write. The result sits in an output
// register, so the next command is taken while it waits; a result still
// waiting holds the following command in its result load cycle. The size
// table needs no clearing pass: per-entry valid bits make unwritten blocks
// read zero. Configuration writes are always ready; write them only when idle.
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  // command stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // block_index[3:0], block_size[19:4],
                                            // request_size[35:20], zero pad
  input  wire logic        s_axis_tuser_i,  // command
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [47:0] m_axis_tdata_o,  // chosen_block[3:0], internal_frag[23:4],
                                            // external_frag[43:24], zero pad
  output logic             m_axis_tuser_o   // found
);
  import fpba_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SW = SIZE_BITS + 5;  // up to 31 blocks summed

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_SCAN = 7'b0000100,
    ST_TAIL = 7'b0001000,
    ST_UPD  = 7'b0010000,
    ST_FIX  = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [1:0] fit_mode_q;
  logic [4:0] block_count_q;

  // latched command
  logic        cmd_q;
  logic [3:0]  bidx_q;
  logic [15:0] bsize_q;
  logic [15:0] req_q;
  logic [4:0]  n_q, n_d;

  // scan counter and read pipeline
  logic [4:0]    k_q, k_d;
  logic          rd_pend_q;
  logic [IW-1:0] ent_idx_q;

  logic [NUM_BLOCKS-1:0] used_q;

  // memory port
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [SIZE_BITS-1:0] mem_wdata, mem_rdata;

  // scan unit
  scan_ctrl_t           sc;
  logic                 have;
  logic [IW-1:0]        pick;
  logic [SIZE_BITS-1:0] best, new_size;
  logic [SW-1:0]        used_sum, free_sum;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_found_q;
  logic [3:0]  out_chosen_q;
  logic [19:0] out_ifrag_q, out_efrag_q;
  logic        out_load;

  logic in_xfer, cfg_xfer, bidx_in_range;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_xfer        = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign bidx_in_range   = 32'(bidx_q) < NUM_BLOCKS;

  // saturate the block count to the table size
  always_comb begin
    if (32'(block_count_q) > NUM_BLOCKS) begin
      n_d = 5'(NUM_BLOCKS);
    end else begin
      n_d = block_count_q;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    mem_we    = 1'b0;
    mem_waddr = IW'(bidx_q);
    mem_wdata = SIZE_BITS'(bsize_q);
    mem_re    = 1'b0;
    mem_raddr = IW'(k_q);
    out_load  = 1'b0;
    sc        = '0;
    sc.alloc  = (cmd_q == CMD_ALLOC);
    sc.entry_used = used_q[ent_idx_q];
    sc.step   = rd_pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sc.clear = 1'b1;
          k_d      = '0;
          if (s_axis_tuser_i == CMD_LOAD) begin
            state_d = ST_LOAD;
          end else if (n_d == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        mem_we = bidx_in_range;
        state_d = (n_q == '0) ? ST_RESP : ST_SCAN;
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        k_d    = k_q + 5'd1;
        if (k_q == n_q - 5'd1) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last entry goes through the scan unit this cycle
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (have) begin
          mem_we    = 1'b1;
          mem_waddr = pick;
          mem_wdata = new_size;
          state_d   = ST_FIX;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_FIX: begin
        sc.fix  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fit_mode_q    <= FIT_MODE_RST;
      block_count_q <= BLOCK_COUNT_RST;
      rd_pend_q     <= 1'b0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      k_q           <= '0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= mem_re;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
          default:         ;
        endcase
      end
      if (state_q == ST_LOAD && bidx_in_range) begin
        used_q[IW'(bidx_q)] <= 1'b0;
      end else if (state_q == ST_UPD && have) begin
        used_q[pick] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= s_axis_tuser_i;
      bidx_q  <= s_axis_tdata_i[3:0];
      bsize_q <= s_axis_tdata_i[19:4];
      req_q   <= s_axis_tdata_i[35:20];
      n_q     <= n_d;
    end
    if (mem_re) begin
      ent_idx_q <= mem_raddr;
    end
    if (out_load) begin
      out_found_q  <= have;
      out_chosen_q <= have ? 4'(pick) : 4'd0;
      out_ifrag_q  <= (64'(used_sum) > 64'(FRAG_MAX)) ? FRAG_MAX : 20'(used_sum);
      out_efrag_q  <= (64'(free_sum) > 64'(FRAG_MAX)) ? FRAG_MAX : 20'(free_sum);
    end
  end

  fpba_size_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  fpba_scan_unit #(
    .SIZE_BITS (SIZE_BITS),
    .IW        (IW),
    .SW        (SW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sc),
    .fit_mode_i (fit_mode_q),
    .req_i      (req_q),
    .size_i     (mem_rdata),
    .index_i    (ent_idx_q),
    .have_o     (have),
    .pick_o     (pick),
    .best_o     (best),
    .new_size_o (new_size),
    .used_sum_o (used_sum),
    .free_sum_o (free_sum)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tdata_o  = {4'd0, out_efrag_q, out_ifrag_q, out_chosen_q};

  // assertions
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (k_q < n_q))
    else $error("scan address past active block count");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == ST_SCAN))
    else $error("read data pending outside a scan");

  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && have) |-> (32'(best) >= 32'(req_q)))
    else $error("chosen block smaller than request");

endmodule

`default_nettype wire

[rtl/fpba_size_mem.sv]
// Remaining-size memory with per-entry valid bits so unwritten entries read zero.
`default_nettype none

module fpba_size_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[rtl/fpba_scan_unit.sv]
// Shared compare/accumulate unit: picks the block and keeps the running totals.
`default_nettype none

module fpba_scan_unit #(
  parameter int SIZE_BITS = 16,
  parameter int IW        = 4,
  parameter int SW        = 21
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fpba_pkg::scan_ctrl_t  ctrl_i,
  input  wire logic [1:0]            fit_mode_i,
  input  wire logic [15:0]           req_i,
  input  wire logic [SIZE_BITS-1:0]  size_i,
  input  wire logic [IW-1:0]         index_i,
  output logic                       have_o,
  output logic      [IW-1:0]         pick_o,
  output logic      [SIZE_BITS-1:0]  best_o,
  output logic      [SIZE_BITS-1:0]  new_size_o,
  output logic      [SW-1:0]         used_sum_o,
  output logic      [SW-1:0]         free_sum_o
);
  import fpba_pkg::*;

  logic                 have_q, have_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic                 pick_used_q, pick_used_d;
  logic [SW-1:0]        u_q, u_d, f_q, f_d;
  logic                 fits, take;

  assign fits       = ctrl_i.alloc && (32'(size_i) >= 32'(req_i));
  assign new_size_o = best_q - SIZE_BITS'(req_i);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!have_q) begin
        take = 1'b1;
      end else begin
        unique case (fit_mode_i)
          FIT_BEST:  take = size_i < best_q;
          FIT_WORST: take = size_i > best_q;
          default:   take = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    have_d      = have_q;
    pick_d      = pick_q;
    best_d      = best_q;
    pick_used_d = pick_used_q;
    u_d         = u_q;
    f_d         = f_q;
    priority if (ctrl_i.clear) begin
      have_d = 1'b0;
      u_d    = '0;
      f_d    = '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.entry_used) begin
        u_d = u_q + SW'(size_i);
      end else begin
        f_d = f_q + SW'(size_i);
      end
      if (take) begin
        have_d      = 1'b1;
        pick_d      = index_i;
        best_d      = size_i;
        pick_used_d = ctrl_i.entry_used;
      end
    end else if (ctrl_i.fix) begin
      // chosen block moves to the used total at its shrunk size
      if (pick_used_q) begin
        u_d = u_q - SW'(req_i);
      end else begin
        f_d = f_q - SW'(best_q);
        u_d = u_q + SW'(new_size_o);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    best_q      <= best_d;
    pick_used_q <= pick_used_d;
    u_q         <= u_d;
    f_q         <= f_d;
  end

  assign have_o     = have_q;
  assign pick_o     = pick_q;
  assign best_o     = best_q;
  assign used_sum_o = u_q;
  assign free_sum_o = f_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the fit policy block allocator.
module testbench;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS     = 16;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 30;    // idle margin before the final check
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic        found;
    logic [3:0]  chosen;
    logic [19:0] used_space;
    logic [19:0] free_space;
  } alloc_result_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_FIT_MODE;
  logic [4:0]  cfg_data  = '0;
  logic        s_valid   = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic        s_tuser   = CMD_LOAD;
  logic        m_ready   = 1'b0;
  logic        cfg_ready;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tuser;

  // shadow of the block's table and registers
  logic [15:0] table_size [NUM_BLOCKS];
  logic        table_used [NUM_BLOCKS];
  logic [1:0]  fit_mode_q    = FIT_MODE_RST;
  logic [4:0]  block_count_q = BLOCK_COUNT_RST;

  alloc_result_t pending_allocs[$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_trigger   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int error_count    = 0;
  int load_count     = 0;
  int alloc_count    = 0;
  int placed_count   = 0;
  int cfg_count      = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  fit_policy_block_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Applies one command to the shadow table and returns the result it yields.
  function automatic alloc_result_t predict_command(input logic cmd, input logic [3:0] idx,
                                                    input logic [15:0] size_v,
                                                    input logic [15:0] req);
    alloc_result_t r;
    int            n;
    int            pick;
    bit            have;
    int unsigned   used_sum;
    int unsigned   free_sum;
    r        = '0;
    have     = 1'b0;
    pick     = 0;
    used_sum = 0;
    free_sum = 0;
    n = (block_count_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count_q);
    if (cmd == CMD_LOAD) begin
      table_size[idx] = size_v;
      table_used[idx] = 1'b0;
      load_count++;
    end else begin
      alloc_count++;
      for (int k = 0; k < n; k++) begin
        if (table_size[k] >= req) begin
          if (!have) begin
            have = 1'b1;
            pick = k;
            // first fit (and the spare code) stops at the first hit
            if (fit_mode_q != FIT_BEST && fit_mode_q != FIT_WORST) break;
          end else if (fit_mode_q == FIT_BEST && table_size[k] < table_size[pick]) begin
            pick = k;
          end else if (fit_mode_q == FIT_WORST && table_size[k] > table_size[pick]) begin
            pick = k;
          end
        end
      end
      if (have) begin
        table_size[pick] = table_size[pick] - req;
        table_used[pick] = 1'b1;
        r.found  = 1'b1;
        r.chosen = pick[3:0];
        placed_count++;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (table_used[k]) used_sum += table_size[k];
      else free_sum += table_size[k];
    end
    r.used_space = (used_sum > FRAG_MAX) ? FRAG_MAX : used_sum[19:0];
    r.free_space = (free_sum > FRAG_MAX) ? FRAG_MAX : free_sum[19:0];
    return r;
  endfunction

  function automatic logic [15:0] random_size();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 15));   // small values make ties likely
      1:       return {8'($urandom_range(1, 8)), 8'h00};
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_request();
    logic [15:0] near;
    near = table_size[$urandom_range(0, NUM_BLOCKS - 1)];
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return near;                          // exact fit
      2:       return near - 16'($urandom_range(0, 3));
      3:       return near + 16'd1;
      4:       return 16'($urandom_range(1, 64));
      5:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One command transfer; valid drops only at the start of a gap.
  task automatic send_command(input logic cmd, input logic [3:0] idx,
                              input logic [15:0] size_v, input logic [15:0] req);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0, req, size_v, idx};
    do @(posedge clk_i); while (!s_tready);
    pending_allocs.push_back(predict_command(cmd, idx, size_v, req));
  endtask

  task automatic wait_all_results();
    s_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_register(input logic idx, input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIT_MODE) fit_mode_q = value[1:0];
    else block_count_q = value;
    cfg_count++;
    @(posedge clk_i);
  endtask

  // Field extremes, every policy, ties, zero request, count zero and saturation.
  task automatic test_directed();
    send_gap_pct   = 21;
    recv_stall_pct = 50;
    send_command(CMD_ALLOC, 4'hF, 16'hFFFF, 16'h0000);  // zero request takes empty block 0
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'h0001);  // nothing fits
    send_command(CMD_LOAD,  4'h0, 16'hFFFF, 16'hFFFF);  // load clears the used mark
    send_command(CMD_LOAD,  4'hF, 16'h8000, 16'h0000);
    send_command(CMD_LOAD,  4'h3, 16'd100,  16'h0000);
    send_command(CMD_LOAD,  4'h7, 16'd100,  16'h0000);  // ties with block 3
    send_command(CMD_LOAD,  4'h9, 16'd5000, 16'h0000);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'd100);
    wait_all_results();
    write_register(CFG_FIT_MODE, {3'b000, FIT_BEST});
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'd100);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'd100);
    wait_all_results();
    write_register(CFG_FIT_MODE, {3'b000, FIT_WORST});
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'h8000);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    wait_all_results();
    write_register(CFG_FIT_MODE, 5'b11111);            // spare policy code
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'h0001);
    wait_all_results();
    write_register(CFG_BLOCK_COUNT, 5'd0);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'h0000);
    send_command(CMD_LOAD,  4'h2, 16'd77,   16'h0000);
    wait_all_results();
    write_register(CFG_BLOCK_COUNT, 5'd1);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'h0002);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    wait_all_results();
    write_register(CFG_BLOCK_COUNT, 5'd31);            // saturates to the table size
    write_register(CFG_FIT_MODE, {3'b000, FIT_BEST});
    send_command(CMD_LOAD,  4'hF, 16'hFFFF, 16'h0000);
    send_command(CMD_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    send_command(CMD_LOAD,  4'hA, 16'h5A5A, 16'hA5A5);
    send_command(CMD_ALLOC, 4'h5, 16'hA5A5, 16'h5A5A);
    wait_all_results();
    write_register(CFG_FIT_MODE, {3'b000, FIT_FIRST});
    write_register(CFG_BLOCK_COUNT, 5'd16);
  endtask

  // Mostly fill-then-allocate sequences under a fresh setting, some random noise.
  task automatic test_random_phase(input int gap_pct, input int stall_pct, input int items);
    int         sent;
    int         batch;
    logic [4:0] count_v;
    sent           = 0;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < items) begin
      wait_all_results();
      write_register(CFG_FIT_MODE, {3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))});
      case ($urandom_range(0, 9))
        0:       count_v = 5'd0;
        1:       count_v = 5'd31;
        2:       count_v = 5'($urandom_range(17, 30));
        3:       count_v = 5'd1;
        default: count_v = 5'($urandom_range(1, 16));
      endcase
      write_register(CFG_BLOCK_COUNT, count_v);
      if ($urandom_range(0, 9) < 8) begin
        batch = $urandom_range(4, 16);
        for (int i = 0; i < batch; i++)
          send_command(CMD_LOAD, ($urandom_range(0, 1) != 0) ? 4'(i) : 4'($urandom),
                       random_size(), 16'($urandom));
        sent += batch;
        batch = $urandom_range(4, 16);
        for (int i = 0; i < batch; i++)
          send_command(CMD_ALLOC, 4'($urandom), 16'($urandom), random_request());
        sent += batch;
      end else begin
        for (int i = 0; i < 8; i++)
          send_command(($urandom_range(0, 1) != 0) ? CMD_ALLOC : CMD_LOAD, 4'($urandom),
                       16'($urandom), 16'($urandom));
        sent += 8;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain.
  task automatic test_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    wait_all_results();
    write_register(CFG_FIT_MODE, {3'b000, FIT_WORST});
    write_register(CFG_BLOCK_COUNT, 5'd16);
    hold_trigger <= hold_trigger + 1;
    for (int i = 0; i < 12; i++)
      send_command(CMD_LOAD, 4'(i), random_size(), 16'($urandom));
    for (int i = 0; i < 12; i++)
      send_command(CMD_ALLOC, 4'($urandom), 16'($urandom), random_request());
    wait_all_results();
    for (int i = 0; i < 6; i++)
      send_command(CMD_ALLOC, 4'($urandom), 16'($urandom), random_request());
    wait_all_results();
  endtask

  // Result side: check every transfer, drive tready with random stalls or a hold-off.
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && m_tvalid && m_ready) begin
      got.found      = m_tuser;
      got.chosen     = m_tdata[3:0];
      got.used_space = m_tdata[23:4];
      got.free_space = m_tdata[43:24];
      if (pending_allocs.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("error: result with nothing expected: found=%0b block=%0d int=%0d ext=%0d",
                   got.found, got.chosen, got.used_space, got.free_space);
        error_count++;
      end else begin
        want = pending_allocs.pop_front();
        if (got.found !== want.found || got.chosen !== want.chosen ||
            got.used_space !== want.used_space || got.free_space !== want.free_space) begin
          if (error_count < REPORT_LIMIT)
            $display({"mismatch: exp found=%0b block=%0d int=%0d ext=%0d,",
                      " got found=%0b block=%0d int=%0d ext=%0d"},
                     want.found, want.chosen, want.used_space, want.free_space,
                     got.found, got.chosen, got.used_space, got.free_space);
          error_count++;
        end
      end
    end
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any transfer on any channel.
  always @(posedge clk_i) begin
    if ((s_valid && s_tready) || (m_tvalid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_allocs.size());
      $display("FAIL fit_policy_block_allocator");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      table_size[k] = '0;
      table_used[k] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(21, 50, 125);
    test_random_phase(50, 21, 125);
    test_random_phase(0, 0, 125);
    test_backpressure();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_allocs.size() != 0)
      $display("error: %0d expected results never arrived", pending_allocs.size());
    $display("Ran %0d loads and %0d allocates (%0d placed) through %0d register writes,",
             load_count, alloc_count, placed_count, cfg_count);
    $display("  all fit modes, block counts 0 to 31, random stalls and a long hold-off.");
    if (error_count == 0 && pending_allocs.size() == 0)
      $display("PASS fit_policy_block_allocator");
    else
      $display("FAIL fit_policy_block_allocator");
    $finish;
  end

endmodule
